// ----- hw/rtl/wspa_pkg.sv -----
`default_nettype none

package wspa_pkg;

  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int TIME_W      = 32;
  localparam int OUT_W       = 24;
  localparam int FILL_W      = 4;

  // 60000 rpm per (revolution per ms), scaled to Q8
  localparam logic [OUT_W-1:0] RPM_SCALE_Q8 = 24'd15360000;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd20;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET      = 16'd2500;
  localparam logic [CFG_W-1:0] UPDATE_RESET       = 16'd300;
  localparam logic [CFG_W-1:0] SPEED_FACTOR_RESET = 16'd8042;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_TIMEOUT      = 2'd1,
    REG_UPDATE       = 2'd2,
    REG_SPEED_FACTOR = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_PULSE  = 1'b0,
    CMD_UPDATE = 1'b1
  } command_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wheel_speed_pulse_averager_top.sv -----
`default_nettype none

// Moving-average pulse tachometer. Items carry a command (hall pulse or update
// request) and a wrapping millisecond timestamp. Pulses build a window of the
// last WINDOW_DEPTH periods above the debounce threshold; an update request
// that comes at least update_period_ms after the last acting update returns one
// result: either a stop indication (no pulse within timeout_ms, averaging state
// cleared) or rpm = 60000*count/sum and speed = rpm*factor>>16, both Q8.
// One item is in work at a time. A pulse that enters the window goes on to drop
// the oldest period from the sum and add its own; an acting update that is a
// stop or finds an empty window goes straight to the output register, and
// otherwise first runs the bit-serial divider, which runs on the single shared
// add/subtract unit. A
// result held in the output register lets the next item in; an acting update
// waits there only while the previous result is still stalled. The window sits
// in a RAM whose entries carry valid bits, so reset and timeout clear it at once.
module wheel_speed_pulse_averager_top
  import wspa_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   item_valid,
  output      logic                   item_stall,
  input  wire logic                   command,
  input  wire logic [TIME_W-1:0]      timestamp_ms,
  output      logic                   result_valid,
  input  wire logic                   result_stall,
  output      logic [OUT_W-1:0]       rpm_q8,
  output      logic [OUT_W-1:0]       speed_q8,
  output      logic                   stopped,
  output      logic [FILL_W-1:0]      window_fill
);

  localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int COUNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = TIME_W + $clog2(WINDOW_DEPTH);
  localparam int ALU_W     = SUM_W + 1;
  localparam int NUM_W     = OUT_W + COUNT_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PULSE,
    S_SUB,
    S_ADD,
    S_ELAPSED,
    S_GAP,
    S_DIV,
    S_MUL,
    S_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] timeout_ms;
  logic [CFG_W-1:0] update_period_ms;
  logic [CFG_W-1:0] speed_factor_q16;

  logic                    cmd_r;
  logic [TIME_W-1:0]       time_r;
  logic [TIME_W-1:0]       period;
  logic [SUM_W-1:0]        window_sum;
  logic [SLOT_W-1:0]       write_slot;
  logic [COUNT_W-1:0]      sample_count;
  logic [WINDOW_DEPTH-1:0] slot_valid;
  logic [TIME_W-1:0]       last_pulse_time;
  logic                    reference_valid;
  logic [TIME_W-1:0]       last_update_time;
  logic [OUT_W-1:0]        held_rpm;
  logic [OUT_W-1:0]        held_speed;
  logic                    stop_flag;
  logic [NUM_W-1:0]        div_q;
  logic [SUM_W-1:0]        div_rem;
  logic [DIV_CNT_W-1:0]    div_cnt;

  // shared add/subtract unit
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic             alu_add;
  logic [ALU_W:0]   alu_res;
  logic             alu_borrow;
  logic [TIME_W-1:0] alu_diff32;

  logic [TIME_W-1:0]          ram_rd_data;
  logic [TIME_W-1:0]          old_period;
  logic                       ram_wr_en;
  logic [NUM_W-1:0]           numerator;
  logic [NUM_W-1:0]           q_next;
  logic [OUT_W+CFG_W-1:0]     speed_prod;
  logic [COUNT_W+FILL_W-1:0]  fill_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms      <= DEBOUNCE_RESET;
      timeout_ms       <= TIMEOUT_RESET;
      update_period_ms <= UPDATE_RESET;
      speed_factor_q16 <= SPEED_FACTOR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:     debounce_ms      <= cfg_data;
        REG_TIMEOUT:      timeout_ms       <= cfg_data;
        REG_UPDATE:       update_period_ms <= cfg_data;
        REG_SPEED_FACTOR: speed_factor_q16 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_add = 1'b0;
    unique case (state)
      S_PULSE, S_GAP: begin
        alu_a = ALU_W'(time_r);
        alu_b = ALU_W'(last_pulse_time);
      end
      S_SUB: begin
        alu_a = ALU_W'(window_sum);
        alu_b = ALU_W'(old_period);
      end
      S_ADD: begin
        alu_a   = ALU_W'(window_sum);
        alu_b   = ALU_W'(period);
        alu_add = 1'b1;
      end
      S_ELAPSED: begin
        alu_a = ALU_W'(time_r);
        alu_b = ALU_W'(last_update_time);
      end
      S_DIV: begin
        alu_a = {div_rem, div_q[NUM_W-1]};
        alu_b = ALU_W'(window_sum);
      end
      default: ;
    endcase
  end

  assign alu_res    = alu_add ? ({1'b0, alu_a} + {1'b0, alu_b})
                              : ({1'b0, alu_a} - {1'b0, alu_b});
  assign alu_borrow = alu_res[ALU_W];
  assign alu_diff32 = alu_res[TIME_W-1:0];

  assign old_period = slot_valid[write_slot] ? ram_rd_data : '0;
  assign ram_wr_en  = (state == S_ADD);
  assign numerator  = NUM_W'(RPM_SCALE_Q8) * NUM_W'(sample_count);
  assign q_next     = {div_q[NUM_W-2:0], ~alu_borrow};
  assign speed_prod = held_rpm * speed_factor_q16;
  assign fill_ext   = {{FILL_W{1'b0}}, sample_count};

  wspa_ram #(
    .WIDTH (TIME_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (write_slot),
    .wr_data (period),
    .rd_addr (write_slot),
    .rd_data (ram_rd_data)
  );

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      window_sum       <= '0;
      write_slot       <= '0;
      sample_count     <= '0;
      slot_valid       <= '0;
      last_pulse_time  <= '0;
      reference_valid  <= 1'b0;
      last_update_time <= '0;
      held_rpm         <= '0;
      held_speed       <= '0;
      stop_flag        <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (result_valid && !result_stall && state != S_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            cmd_r  <= command;
            time_r <= timestamp_ms;
            state  <= (command_t'(command) == CMD_PULSE) ? S_PULSE : S_ELAPSED;
          end
        end
        S_PULSE: begin
          period          <= alu_diff32;
          last_pulse_time <= time_r;
          reference_valid <= 1'b1;
          if (reference_valid && alu_diff32 > TIME_W'(debounce_ms)) begin
            state <= S_SUB;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SUB: begin
          // drop the oldest period from the sum
          window_sum <= alu_res[SUM_W-1:0];
          state      <= S_ADD;
        end
        S_ADD: begin
          window_sum             <= alu_res[SUM_W-1:0];
          slot_valid[write_slot] <= 1'b1;
          write_slot <= (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : write_slot + 1'b1;
          if (sample_count < COUNT_W'(WINDOW_DEPTH)) begin
            sample_count <= sample_count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_ELAPSED: begin
          if (alu_diff32 < TIME_W'(update_period_ms)) begin
            state <= S_IDLE;
          end else begin
            last_update_time <= time_r;
            state            <= S_GAP;
          end
        end
        S_GAP: begin
          if (reference_valid && alu_diff32 > TIME_W'(timeout_ms)) begin
            // wheel stopped: clear the averaging state, keep the write slot
            slot_valid      <= '0;
            window_sum      <= '0;
            sample_count    <= '0;
            reference_valid <= 1'b0;
            last_pulse_time <= '0;
            held_rpm        <= '0;
            held_speed      <= '0;
            stop_flag       <= 1'b1;
            state           <= S_OUT;
          end else if (sample_count == '0) begin
            stop_flag <= 1'b0;
            state     <= S_OUT;
          end else if (window_sum == '0) begin
            stop_flag <= 1'b0;
            held_rpm  <= RPM_SCALE_Q8;
            state     <= S_MUL;
          end else begin
            stop_flag <= 1'b0;
            div_q     <= numerator;
            div_rem   <= '0;
            div_cnt   <= DIV_CNT_W'(NUM_W - 1);
            state     <= S_DIV;
          end
        end
        S_DIV: begin
          div_q   <= q_next;
          div_rem <= alu_borrow ? alu_a[SUM_W-1:0] : alu_res[SUM_W-1:0];
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            // saturate to the output width
            held_rpm <= (|q_next[NUM_W-1:OUT_W]) ? {OUT_W{1'b1}} : q_next[OUT_W-1:0];
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          held_speed <= speed_prod[OUT_W+CFG_W-1:CFG_W];
          state      <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!result_valid || !result_stall) begin
            rpm_q8       <= held_rpm;
            speed_q8     <= held_speed;
            stopped      <= stop_flag;
            window_fill  <= fill_ext[FILL_W-1:0];
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= COUNT_W'(WINDOW_DEPTH))
    else $error("window count beyond depth");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    sample_count == '0 |-> window_sum == '0)
    else $error("empty window with nonzero sum");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_rem < window_sum)
    else $error("divider remainder not below divisor");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && stopped |-> rpm_q8 == '0 && speed_q8 == '0 && window_fill == '0)
    else $error("stop result carries nonzero values");

  a_pulse_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD |-> command_t'(cmd_r) == CMD_PULSE)
    else $error("window written by an update item");

endmodule

`default_nettype wire

// ----- hw/rtl/wspa_ram.sv -----
`default_nettype none

module wspa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- dv/tach_result_checker.sv -----
`timescale 1ns / 1ps

module tach_result_checker
  import wspa_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   item_valid,
  input  wire logic                   item_stall,
  input  wire logic                   command,
  input  wire logic [TIME_W-1:0]      timestamp_ms,
  input  wire logic                   result_valid,
  input  wire logic                   result_stall,
  input  wire logic [OUT_W-1:0]       rpm_q8,
  input  wire logic [OUT_W-1:0]       speed_q8,
  input  wire logic                   stopped,
  input  wire logic [FILL_W-1:0]      window_fill,
  output int                          mismatches,
  output int                          pending,
  output int                          readings_seen,
  output int                          stops_seen
);

  typedef struct packed {
    logic [OUT_W-1:0]  rpm;
    logic [OUT_W-1:0]  speed;
    logic              stopped;
    logic [FILL_W-1:0] fill;
  } tach_reading_t;

  tach_reading_t expected_readings[$];

  logic [CFG_W-1:0]  debounce_ms;
  logic [CFG_W-1:0]  timeout_ms;
  logic [CFG_W-1:0]  update_period_ms;
  logic [CFG_W-1:0]  speed_factor;

  logic [TIME_W-1:0] periods [WINDOW_DEPTH];
  logic [TIME_W+$clog2(WINDOW_DEPTH)-1:0] period_sum;
  int                slot;
  int                fill;
  logic [TIME_W-1:0] pulse_ref_ms;
  logic              have_ref;
  logic [TIME_W-1:0] last_update_ms;
  logic [OUT_W-1:0]  rpm_hold;
  logic [OUT_W-1:0]  speed_hold;

  initial begin
    mismatches    = 0;
    pending       = 0;
    readings_seen = 0;
    stops_seen    = 0;
  end

  task automatic clear_average();
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      periods[i] = '0;
    end
    period_sum   = '0;
    fill         = 0;
    have_ref     = 1'b0;
    pulse_ref_ms = '0;
    rpm_hold     = '0;
    speed_hold   = '0;
  endtask

  task automatic track_item(input command_t cmd, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] gap;
    logic [63:0]       rpm_full;
    logic [63:0]       scaled;
    tach_reading_t     r;
    if (cmd == CMD_PULSE) begin
      if (have_ref) begin
        gap = now - pulse_ref_ms;
        if (gap > debounce_ms) begin
          period_sum    = period_sum - periods[slot] + gap;
          periods[slot] = gap;
          slot          = (slot + 1 >= WINDOW_DEPTH) ? 0 : slot + 1;
          if (fill < WINDOW_DEPTH) fill++;
        end
      end
      pulse_ref_ms = now;
      have_ref     = 1'b1;
    end else if (TIME_W'(now - last_update_ms) >= update_period_ms) begin
      last_update_ms = now;
      r.stopped = 1'b0;
      if (have_ref && TIME_W'(now - pulse_ref_ms) > timeout_ms) begin
        clear_average();
        r.stopped = 1'b1;
      end else if (fill > 0) begin
        // guard only: every stored period is at least one
        if (period_sum == '0) rpm_full = 64'(RPM_SCALE_Q8);
        else rpm_full = (64'(RPM_SCALE_Q8) * 64'(fill)) / 64'(period_sum);
        if (rpm_full > 64'hFF_FFFF) rpm_full = 64'hFF_FFFF;
        rpm_hold   = rpm_full[OUT_W-1:0];
        scaled     = (64'(rpm_hold) * 64'(speed_factor)) >> 16;
        speed_hold = scaled[OUT_W-1:0];
      end
      r.rpm   = rpm_hold;
      r.speed = speed_hold;
      r.fill  = FILL_W'(fill);
      expected_readings.push_back(r);
    end
  endtask

  task automatic check_reading();
    tach_reading_t want;
    if (expected_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected reading: rpm=%0d speed=%0d stopped=%0b fill=%0d",
                 rpm_q8, speed_q8, stopped, window_fill);
    end else begin
      want = expected_readings.pop_front();
      readings_seen++;
      if (want.stopped) stops_seen++;
      if (rpm_q8 !== want.rpm || speed_q8 !== want.speed ||
          stopped !== want.stopped || window_fill !== want.fill) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("reading %0d: want rpm=%0d speed=%0d stopped=%0b fill=%0d",
                   readings_seen, want.rpm, want.speed, want.stopped, want.fill);
          $display("  got rpm=%0d speed=%0d stopped=%0b fill=%0d",
                   rpm_q8, speed_q8, stopped, window_fill);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      debounce_ms      = DEBOUNCE_RESET;
      timeout_ms       = TIMEOUT_RESET;
      update_period_ms = UPDATE_RESET;
      speed_factor     = SPEED_FACTOR_RESET;
      clear_average();
      slot           = 0;
      last_update_ms = '0;
      expected_readings.delete();
    end else begin
      if (result_valid && !result_stall) check_reading();
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEBOUNCE:     debounce_ms      = cfg_data;
          REG_TIMEOUT:      timeout_ms       = cfg_data;
          REG_UPDATE:       update_period_ms = cfg_data;
          REG_SPEED_FACTOR: speed_factor     = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) track_item(command_t'(command), timestamp_ms);
    end
    pending = expected_readings.size();
  end

endmodule

// ----- dv/tb_wheel_speed_pulse_averager_top.sv -----
`timescale 1ns / 1ps

module tb_wheel_speed_pulse_averager_top;
  import wspa_pkg::*;

  localparam int WINDOW_DEPTH  = 8;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int SQUEEZE_HOLD  = 400;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               item_valid;
  logic               item_stall;
  logic               command;
  logic [TIME_W-1:0]  timestamp_ms;
  logic               result_valid;
  logic               rx_stall;
  logic               long_hold;
  wire                result_stall = rx_stall | long_hold;
  logic [OUT_W-1:0]   rpm_q8;
  logic [OUT_W-1:0]   speed_q8;
  logic               stopped;
  logic [FILL_W-1:0]  window_fill;

  int mismatches;
  int pending;
  int readings_seen;
  int stops_seen;

  logic              tx_calm = 1'b0;
  logic              rx_calm = 1'b0;
  logic              squeeze_req = 1'b0;
  logic [TIME_W-1:0] clock_ms;
  int unsigned       cur_debounce, cur_timeout, cur_update;
  int                items_sent = 0;
  int                settings_used = 1;
  int                cycle_count = 0;

  wheel_speed_pulse_averager_top #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .command, .timestamp_ms,
    .result_valid, .result_stall, .rpm_q8, .speed_q8, .stopped, .window_fill
  );

  tach_result_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_checker (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .command, .timestamp_ms,
    .result_valid, .result_stall, .rpm_q8, .speed_q8, .stopped, .window_fill,
    .mismatches, .pending, .readings_seen, .stops_seen
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stuck after %0d cycles, %0d readings outstanding", cycle_count, pending);
      $display("tb_wheel_speed_pulse_averager_top NOT OK");
      $finish;
    end
  end

  // receiver: random stall before taking each reading
  initial begin
    int wait_cycles;
    rx_stall = 1'b0;
    forever begin
      @(negedge clk);
      wait_cycles = rx_calm ? 0 : $urandom_range(0, 13);
      if (wait_cycles > 0) begin
        rx_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // one long hold-off so the block backs up and stalls its input
  initial begin
    int held;
    long_hold = 1'b0;
    wait (squeeze_req);
    @(negedge clk);
    long_hold <= 1'b1;
    for (held = 0; held < SQUEEZE_HOLD; held++) @(negedge clk);
    long_hold <= 1'b0;
  end

  task automatic send_item(input command_t cmd, input logic [TIME_W-1:0] ts);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid   <= 1'b1;
    command      <= cmd;
    timestamp_ms <= ts;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input int unsigned deb, input int unsigned tmo,
                            input int unsigned upd, input int unsigned fac);
    cfg_write <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= CFG_W'(deb);
    @(negedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= CFG_W'(tmo);
    @(negedge clk);
    cfg_index <= REG_UPDATE;
    cfg_data  <= CFG_W'(upd);
    @(negedge clk);
    cfg_index <= REG_SPEED_FACTOR;
    cfg_data  <= CFG_W'(fac);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_debounce = deb;
    cur_timeout  = tmo;
    cur_update   = upd;
    settings_used++;
  endtask

  // rides of plausible pulse trains and updates, with bounces, stops and stray items
  task automatic ride(input int count);
    int          n;
    int          roll;
    int unsigned spread;
    spread = (cur_timeout > cur_debounce + 8) ? (cur_timeout - cur_debounce) / 4 : 600;
    if (spread > 800) spread = 800;
    if ($urandom_range(0, 2) == 0) clock_ms = $urandom;
    else if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 52) begin
        clock_ms += cur_debounce + 1 + $urandom_range(0, spread);
        send_item(CMD_PULSE, clock_ms);
      end else if (roll < 60) begin
        clock_ms += $urandom_range(0, cur_debounce);
        send_item(CMD_PULSE, clock_ms);
      end else if (roll < 88) begin
        clock_ms += $urandom_range(0, cur_update + cur_update / 2);
        send_item(CMD_UPDATE, clock_ms);
      end else if (roll < 93) begin
        clock_ms += cur_timeout + 1 + $urandom_range(0, 3000);
        send_item(CMD_UPDATE, clock_ms);
      end else begin
        send_item(command_t'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  initial begin
    int k;
    int ph;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_DEBOUNCE;
    cfg_data     = '0;
    item_valid   = 1'b0;
    command      = CMD_PULSE;
    timestamp_ms = '0;
    clock_ms     = '0;
    cur_debounce = DEBOUNCE_RESET;
    cur_timeout  = TIMEOUT_RESET;
    cur_update   = UPDATE_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: early update, first pulse at time zero, bounce, empty window
    send_item(CMD_UPDATE, 32'd0);
    send_item(CMD_PULSE,  32'd0);
    send_item(CMD_PULSE,  32'd10);
    send_item(CMD_UPDATE, 32'd300);
    send_item(CMD_PULSE,  32'd400);
    send_item(CMD_PULSE,  32'd500);
    send_item(CMD_UPDATE, 32'd550);
    send_item(CMD_UPDATE, 32'd600);
    // stop after a long silence, then an update with nothing held
    send_item(CMD_UPDATE, 32'd3200);
    send_item(CMD_UPDATE, 32'd3500);
    // periods across the wrap of the millisecond counter
    send_item(CMD_PULSE,  32'hFFFF_FFFF);
    send_item(CMD_PULSE,  32'h0000_0040);
    send_item(CMD_PULSE,  32'h0000_0100);
    send_item(CMD_UPDATE, 32'h0000_0200);
    // update exactly one period later, then a gap of exactly the timeout
    send_item(CMD_UPDATE, 32'h0000_032C);
    send_item(CMD_UPDATE, 32'h0000_0AC4);
    clock_ms = 32'h0000_0AC4;
    settle();

    // no debounce, no update spacing, full factor: drive rpm to its highest reachable value
    set_config(0, 16'hFFFF, 0, 16'hFFFF);
    for (k = 0; k < 10; k++) begin
      clock_ms += 1;
      send_item(CMD_PULSE, clock_ms);
    end
    send_item(CMD_UPDATE, clock_ms);
    tx_calm     = 1'b1;
    squeeze_req <= 1'b1;
    ride(150);
    tx_calm = 1'b0;
    settle();

    set_config(16'hFFFF, 0, 16'hFFFF, 0);
    ride(100);
    settle();

    for (ph = 0; ph < 5; ph++) begin
      set_config(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 80),
                 ($urandom_range(0, 5) == 0) ? 16'hFFFF : $urandom_range(200, 6000),
                 ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 700),
                 $urandom_range(0, 16'hFFFF));
      tx_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
      rx_calm = (ph == 2) || ($urandom_range(0, 3) == 0);
      ride(190);
      settle();
    end

    $display("run covered %0d items over %0d register settings", items_sent, settings_used);
    $display("checked %0d readings, %0d of them stop reports", readings_seen, stops_seen);
    if (mismatches == 0) begin
      $display("tb_wheel_speed_pulse_averager_top OK");
    end else begin
      $display("tb_wheel_speed_pulse_averager_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/wspa_pkg.sv
hw/rtl/wspa_ram.sv
hw/rtl/wheel_speed_pulse_averager_top.sv
dv/tach_result_checker.sv
dv/tb_wheel_speed_pulse_averager_top.sv
